// File: rtl/falt_pkg.sv
`default_nettype none

package falt_pkg;

	// Register indexes of the configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOOPBACK_ADDRESS = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [31:0] OWN_ADDRESS_RESET      = 32'h0000_0000;
	localparam logic [31:0] LOOPBACK_ADDRESS_RESET = 32'h7F00_0001;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic        have;
		logic [31:0] cand;
	} falt_req_t;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COMPARE
	} falt_state_t;

endpackage

`default_nettype wire

// File: rtl/falt_ram.sv
`default_nettype none

module falt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/falt_front.sv
`default_nettype none

module falt_front
	import falt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data,
	input  wire logic                   push,
	output      logic                   full,
	input  wire logic [31:0]            dest_address,
	input  wire logic [31:0]            source_address,
	input  wire logic                   q_pop,
	output      logic                   q_empty,
	output      falt_req_t              q_req
);

	logic [31:0] own_q;
	logic [31:0] loop_q;
	falt_req_t   entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        dest_excl;
	logic        src_excl;
	falt_req_t   req_in;
	logic        do_push;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= OWN_ADDRESS_RESET;
			loop_q <= LOOPBACK_ADDRESS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OWN_ADDRESS:      own_q  <= cfg_data;
				CFG_LOOPBACK_ADDRESS: loop_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// Pick the candidate: a foreign destination wins, else a foreign source.
	always_comb begin
		dest_excl = (dest_address == loop_q) || (dest_address == own_q);
		src_excl  = (source_address == loop_q) || (source_address == own_q);
		req_in.have = !dest_excl || !src_excl;
		req_in.cand = !dest_excl ? dest_address : source_address;
	end

	assign full    = (fill_q == 2'd2);
	assign q_empty = (fill_q == 2'd0);
	assign do_push = push && !full;
	assign q_req   = entry_q[rd_ptr_q];

	// Two-entry queue toward the search sequencer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (q_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/falt_back.sv
`default_nettype none

module falt_back
	import falt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire falt_req_t   q_req,
	output      logic        q_pop,
	output      logic        empty,
	input  wire logic        pop,
	output      logic        learned,
	output      logic [31:0] learned_address,
	output      logic [6:0]  entries_used,
	output      logic        table_full
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	falt_state_t   state_q;
	falt_state_t   state_d;
	logic [31:0]   cand_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [31:0]   rdata;
	logic          res_valid_q;

	logic          ram_we;
	logic          ram_re;
	logic          idx_clr;
	logic          idx_inc;
	logic          count_inc;
	logic          res_load;
	logic          res_learned;
	logic [31:0]   res_addr;
	logic          res_full;
	logic [CW-1:0] res_count;
	logic [CW+6:0] res_count_wide;

	// Learned addresses in arrival order.
	falt_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(cand_q),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search sequencer: read held entries one by one, then append or drop.
	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		idx_clr     = 1'b0;
		idx_inc     = 1'b0;
		count_inc   = 1'b0;
		res_load    = 1'b0;
		res_learned = 1'b0;
		res_addr    = '0;
		res_full    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty && !res_valid_q) begin
					q_pop = 1'b1;
					if (q_req.have) begin
						idx_clr = 1'b1;
						state_d = ST_CHECK;
					end else begin
						res_load = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (idx_q == count_q) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					if (count_q != DEPTH_C) begin
						ram_we      = 1'b1;
						count_inc   = 1'b1;
						res_learned = 1'b1;
						res_addr    = cand_q;
					end else begin
						res_full = 1'b1;
					end
				end else begin
					ram_re  = 1'b1;
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (rdata == cand_q) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					idx_inc = 1'b1;
					state_d = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_count      = count_inc ? (count_q + CW'(1)) : count_q;
	assign res_count_wide = {7'd0, res_count};

	// Candidate register, loaded as a request leaves the queue.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cand_q <= q_req.cand;
		end
	end

	// Search index and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Result register in front of the output side.
	always_ff @(posedge clk) begin
		if (res_load) begin
			learned         <= res_learned;
			learned_address <= res_addr;
			entries_used    <= res_count_wide[6:0];
			table_full      <= res_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty = !res_valid_q;

endmodule

`default_nettype wire

// File: rtl/foreign_address_learning_table_core.sv
`default_nettype none

// Learns foreign IPv4 addresses from destination/source pairs. A destination
// that is neither the loopback nor the own address is the candidate; failing
// that, the source is. A candidate not yet held is appended to a table of
// TABLE_DEPTH entries, or dropped with table_full set when the table is full.
// Every request gives exactly one result. The front stage classifies a
// request in the cycle it is accepted and holds up to two requests; the back
// searches the table RAM through its single registered read port, reading
// each held entry in ST_CHECK and comparing it in ST_COMPARE, until a match
// or the end of the held entries. A request without a candidate gives its
// result straight from ST_IDLE. The back takes no new request while its
// result waits to be popped. The table needs no clearing after reset; the
// entry count bounds every search.
module foreign_address_learning_table_core
	import falt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data,
	input  wire logic                   push,
	output      logic                   full,
	input  wire logic [31:0]            dest_address,
	input  wire logic [31:0]            source_address,
	output      logic                   empty,
	input  wire logic                   pop,
	output      logic                   learned,
	output      logic [31:0]            learned_address,
	output      logic [6:0]             entries_used,
	output      logic                   table_full
);

	logic      q_pop;
	logic      q_empty;
	falt_req_t q_req;

	// Configuration, classification and the request queue.
	falt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.dest_address  (dest_address),
		.source_address(source_address),
		.q_pop         (q_pop),
		.q_empty       (q_empty),
		.q_req         (q_req)
	);

	// Table search, append and result register.
	falt_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_req          (q_req),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.learned        (learned),
		.learned_address(learned_address),
		.entries_used   (entries_used),
		.table_full     (table_full)
	);

endmodule

`default_nettype wire
